// ===== design/lfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfd_pkg
// Shared widths, register codes and structured types of the fragment
// deframer.
// ----------------------------------------------------------------------------
package lfd_pkg;

	localparam int BYTE_W  = 8;
	localparam int FRAG_W  = 8;
	localparam int ROW_W   = 8;
	localparam int COL_W   = 11;
	localparam int VAL_W   = 16;
	localparam int SLOTS_W = 4;
	localparam int HELD_W  = 24;

	localparam int APB_DW = 32;
	localparam int APB_AW = 4;

	// Register reset values
	localparam logic [SLOTS_W-1:0] RST_SLOTS     = 4'd4;
	localparam logic [ROW_W-1:0]   RST_ROWS      = 8'd96;
	localparam logic [VAL_W-1:0]   RST_MAX_DIST  = 16'd30000;
	localparam logic [VAL_W-1:0]   RST_MAX_INTEN = 16'd318;

	typedef enum logic [1:0] {
		REG_SLOTS     = 2'd0,
		REG_ROWS      = 2'd1,
		REG_MAX_DIST  = 2'd2,
		REG_MAX_INTEN = 2'd3
	} reg_idx_t;

	localparam logic KIND_AMBIENT   = 1'b0;
	localparam logic KIND_REFLECTED = 1'b1;

	typedef struct packed {
		logic [SLOTS_W-1:0] slots;
		logic [ROW_W-1:0]   rows;
		logic [VAL_W-1:0]   max_distance;
		logic [VAL_W-1:0]   max_intensity;
	} cfg_t;

	typedef struct packed {
		logic               pixel_kind;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   column;
		logic [VAL_W-1:0]   pixel_value;
		logic [VAL_W-1:0]   intensity;
		logic               distance_invalid;
		logic               intensity_clamped;
		logic               fragment_done;
	} pixel_t;

endpackage
`default_nettype wire

// ===== design/lfd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfd_if
// Valid/ready channels: the raw byte stream in and the pixel writes out.
// ----------------------------------------------------------------------------
interface lfd_byte_if;
	logic                       valid;
	logic                       ready;
	logic [lfd_pkg::BYTE_W-1:0] data_byte;
	logic [lfd_pkg::FRAG_W-1:0] fragment_number;
	logic                       fragment_start;

	modport source (
		output valid, data_byte, fragment_number, fragment_start,
		input  ready
	);
	modport sink (
		input  valid, data_byte, fragment_number, fragment_start,
		output ready
	);
endinterface

interface lfd_pixel_if;
	logic                      valid;
	logic                      ready;
	logic                      pixel_kind;
	logic [lfd_pkg::ROW_W-1:0] row;
	logic [lfd_pkg::COL_W-1:0] column;
	logic [lfd_pkg::VAL_W-1:0] pixel_value;
	logic [lfd_pkg::VAL_W-1:0] intensity;
	logic                      distance_invalid;
	logic                      intensity_clamped;
	logic                      fragment_done;

	modport source (
		output valid, pixel_kind, row, column, pixel_value, intensity,
		       distance_invalid, intensity_clamped, fragment_done,
		input  ready
	);
	modport sink (
		input  valid, pixel_kind, row, column, pixel_value, intensity,
		       distance_invalid, intensity_clamped, fragment_done,
		output ready
	);
endinterface
`default_nettype wire

// ===== design/lfd_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfd_apb_regs
// APB register file holding slot count, row count and the two limits.
// ----------------------------------------------------------------------------
module lfd_apb_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [lfd_pkg::APB_AW-1:0] paddr,
	input  wire logic [lfd_pkg::APB_DW-1:0] pwdata,
	output logic      [lfd_pkg::APB_DW-1:0] prdata,
	output logic                            pready,
	output lfd_pkg::cfg_t                   cfg
);
	import lfd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slots         <= RST_SLOTS;
			cfg_q.rows          <= RST_ROWS;
			cfg_q.max_distance  <= RST_MAX_DIST;
			cfg_q.max_intensity <= RST_MAX_INTEN;
		end else if (wr_en) begin
			case (idx)
				REG_SLOTS:     cfg_q.slots         <= pwdata[SLOTS_W-1:0];
				REG_ROWS:      cfg_q.rows          <= pwdata[ROW_W-1:0];
				REG_MAX_DIST:  cfg_q.max_distance  <= pwdata[VAL_W-1:0];
				REG_MAX_INTEN: cfg_q.max_intensity <= pwdata[VAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SLOTS:     prdata = {{(APB_DW-SLOTS_W){1'b0}}, cfg_q.slots};
			REG_ROWS:      prdata = {{(APB_DW-ROW_W){1'b0}}, cfg_q.rows};
			REG_MAX_DIST:  prdata = {{(APB_DW-VAL_W){1'b0}}, cfg_q.max_distance};
			REG_MAX_INTEN: prdata = {{(APB_DW-VAL_W){1'b0}}, cfg_q.max_intensity};
			default:       prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/lfd_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfd_parse
// Input register, slot position state and per-byte pixel decode.
// ----------------------------------------------------------------------------
module lfd_parse #(
	parameter int AMBIENT_ROWS       = 192,
	parameter int RESERVED_BYTES     = 16,
	parameter int MAX_SLOTS          = 8,
	parameter int MAX_REFLECTED_ROWS = 192
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [lfd_pkg::BYTE_W-1:0] data_byte,
	input  wire logic [lfd_pkg::FRAG_W-1:0] fragment_number,
	input  wire logic                       fragment_start,
	input  wire lfd_pkg::cfg_t              cfg,
	input  wire logic                       adv,
	output logic                            res_valid,
	output lfd_pkg::pixel_t                 res
);
	import lfd_pkg::*;

	localparam int POS_W  = $clog2(RESERVED_BYTES + AMBIENT_ROWS + 4 * MAX_REFLECTED_ROWS + 1);
	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CMP_W  = ((POS_W > ROW_W) ? POS_W : ROW_W) + 1;
	localparam int PROD_W = FRAG_W + SLOTS_W;

	localparam logic [POS_W-1:0]   RES_END   = POS_W'(RESERVED_BYTES);
	localparam logic [POS_W-1:0]   AMB_END   = POS_W'(RESERVED_BYTES + AMBIENT_ROWS);
	localparam logic [SLOTS_W:0]   SLOTS_CAP = (SLOTS_W + 1)'(MAX_SLOTS);
	localparam logic [ROW_W:0]     ROWS_CAP  = (ROW_W + 1)'(MAX_REFLECTED_ROWS);
	localparam logic [1:0]         LANE_LAST = 2'd3;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [FRAG_W-1:0] fnum_s1;
	logic              start_s1;

	// deframing state
	logic [POS_W-1:0]  byte_offset_q;
	logic [SLOT_W-1:0] slot_index_q;
	logic [HELD_W-1:0] held_q;
	logic [FRAG_W-1:0] frag_q;
	logic              finished_q;

	logic              step;
	logic [POS_W-1:0]  pos;
	logic [SLOT_W-1:0] slot_a;
	logic [HELD_W-1:0] held_a;
	logic [FRAG_W-1:0] frag_a;
	logic              fin_a;

	logic [SLOTS_W-1:0] eff_slots;
	logic [ROW_W-1:0]   eff_rows;
	logic [PROD_W-1:0]  col_sum;
	logic [POS_W-1:0]   refl_off;
	logic [POS_W-1:0]   row_full;
	logic [1:0]         lane;
	logic               in_reserved;
	logic               in_ambient;
	logic               past_end;
	logic               last_row;
	logic               last_slot;
	logic [HELD_W-1:0]  lane_bits;
	logic [VAL_W-1:0]   dist_raw;
	logic [VAL_W-1:0]   inten_raw;
	logic               dist_bad;
	logic               inten_big;

	logic [POS_W-1:0]  nxt_off;
	logic [SLOT_W-1:0] nxt_slot;
	logic [HELD_W-1:0] nxt_held;
	logic              nxt_fin;
	logic              emit;
	logic              end_slot;
	pixel_t            pix;

	assign in_ready = !valid_s1 || adv;
	assign step     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= data_byte;
			fnum_s1  <= fragment_number;
			start_s1 <= fragment_start;
		end
	end

	// A fragment start rewinds the position before this byte is decoded
	assign pos    = start_s1 ? '0 : byte_offset_q;
	assign slot_a = start_s1 ? '0 : slot_index_q;
	assign held_a = start_s1 ? '0 : held_q;
	assign frag_a = start_s1 ? fnum_s1 : frag_q;
	assign fin_a  = start_s1 ? 1'b0 : finished_q;

	always_comb begin
		if (cfg.slots == '0) begin
			eff_slots = SLOTS_W'(1);
		end else if ({1'b0, cfg.slots} > SLOTS_CAP) begin
			eff_slots = SLOTS_CAP[SLOTS_W-1:0];
		end else begin
			eff_slots = cfg.slots;
		end
		if (cfg.rows == '0) begin
			eff_rows = ROW_W'(1);
		end else if ({1'b0, cfg.rows} > ROWS_CAP) begin
			eff_rows = ROWS_CAP[ROW_W-1:0];
		end else begin
			eff_rows = cfg.rows;
		end
	end

	assign col_sum     = frag_a * eff_slots + PROD_W'(slot_a);
	assign in_reserved = pos < RES_END;
	assign in_ambient  = pos < AMB_END;
	assign refl_off    = pos - AMB_END;
	assign row_full    = refl_off >> 2;
	assign lane        = refl_off[1:0];
	assign past_end    = CMP_W'(row_full) >= CMP_W'(eff_rows);
	assign last_row    = (CMP_W'(row_full) + 1'b1) >= CMP_W'(eff_rows);
	assign last_slot   = ((SLOTS_W + 1)'(slot_a) + 1'b1) >= {1'b0, eff_slots};
	assign lane_bits   = HELD_W'(byte_s1) << {lane, 3'b000};

	assign dist_raw  = held_a[VAL_W-1:0];
	assign inten_raw = {byte_s1, held_a[HELD_W-1:VAL_W]};
	assign dist_bad  = dist_raw > cfg.max_distance;
	assign inten_big = inten_raw > cfg.max_intensity;

	always_comb begin
		nxt_off  = pos;
		nxt_slot = slot_a;
		nxt_held = held_a;
		nxt_fin  = fin_a;
		emit     = 1'b0;
		end_slot = 1'b0;
		pix        = '0;
		pix.column = col_sum[COL_W-1:0];
		if (!fin_a) begin
			if (in_reserved) begin
				nxt_off = pos + 1'b1;
			end else if (in_ambient) begin
				nxt_off         = pos + 1'b1;
				emit            = 1'b1;
				pix.pixel_kind  = KIND_AMBIENT;
				pix.row         = ROW_W'(pos - RES_END);
				pix.pixel_value = VAL_W'(byte_s1);
			end else if (past_end) begin
				// slot shortened under the current position: close it
				end_slot = 1'b1;
			end else if (lane != LANE_LAST) begin
				nxt_held = held_a | lane_bits;
				nxt_off  = pos + 1'b1;
			end else begin
				emit                  = 1'b1;
				pix.pixel_kind        = KIND_REFLECTED;
				pix.row               = ROW_W'(row_full);
				pix.pixel_value       = dist_bad ? '0 : dist_raw;
				pix.intensity         = inten_big ? cfg.max_intensity : inten_raw;
				pix.distance_invalid  = dist_bad;
				pix.intensity_clamped = inten_big;
				pix.fragment_done     = last_row && last_slot;
				nxt_held              = '0;
				if (last_row) begin
					end_slot = 1'b1;
				end else begin
					nxt_off = pos + 1'b1;
				end
			end
			if (end_slot) begin
				nxt_off  = '0;
				nxt_held = '0;
				if (last_slot) begin
					nxt_fin = 1'b1;
				end else begin
					nxt_slot = slot_a + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= '0;
			slot_index_q  <= '0;
			held_q        <= '0;
			frag_q        <= '0;
			finished_q    <= 1'b0;
		end else if (step) begin
			byte_offset_q <= nxt_off;
			slot_index_q  <= nxt_slot;
			held_q        <= nxt_held;
			frag_q        <= frag_a;
			finished_q    <= nxt_fin;
		end
	end

	assign res_valid = step && emit;
	assign res       = pix;

endmodule
`default_nettype wire

// ===== design/lfd_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfd_out_stage
// Result register toward the pixel sink; frees up when the sink takes it.
// ----------------------------------------------------------------------------
module lfd_out_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            res_valid,
	input  wire lfd_pkg::pixel_t res,
	output logic                 adv,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output lfd_pkg::pixel_t      out_pix
);
	import lfd_pkg::*;

	logic   valid_s2;
	pixel_t pix_s2;

	assign adv       = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_pix   = pix_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			pix_s2 <= res;
		end
	end

endmodule
`default_nettype wire

// ===== design/lidar_fragment_deframer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_fragment_deframer_core
// Turns a sensor fragment byte stream into ambient and reflected pixel writes.
//
// byte_in carries one stream byte per request with its fragment number and a
// start mark; pixel_out carries at most one pixel write per byte. Each slot
// of a fragment is skipped over its reserved bytes, then every ambient byte
// gives an ambient write and the fourth byte of every reflected row gives a
// reflected write with limit-checked distance and intensity. Bytes past the
// last slot give nothing until the next start mark.
//
// Throughput: one byte per cycle while the sink does not stall, set by
// the single combinational decode step between the input register and
// the result register. When the sink stalls, the output register holds
// its request; the input register takes a byte only while empty, after
// that byte_in.ready drops. Reset (arst_n low) clears the slot position,
// returns the registers to their defaults and empties both stages. The
// APB port is to be written only while the block is idle, which the
// block does not enforce itself; pready is always high.
// ----------------------------------------------------------------------------
module lidar_fragment_deframer_core #(
	parameter int AMBIENT_ROWS       = 192,
	parameter int RESERVED_BYTES     = 16,
	parameter int MAX_SLOTS          = 8,
	parameter int MAX_REFLECTED_ROWS = 192
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	lfd_byte_if.sink                        byte_in,
	lfd_pixel_if.source                     pixel_out,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [lfd_pkg::APB_AW-1:0] paddr,
	input  wire logic [lfd_pkg::APB_DW-1:0] pwdata,
	output logic      [lfd_pkg::APB_DW-1:0] prdata,
	output logic                            pready
);
	import lfd_pkg::*;

	cfg_t   cfg;
	pixel_t res;
	pixel_t out_pix;
	logic   res_valid;
	logic   adv;

	// Register file: limits and slot geometry
	lfd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register plus position tracking and pixel decode
	lfd_parse #(
		.AMBIENT_ROWS       (AMBIENT_ROWS),
		.RESERVED_BYTES     (RESERVED_BYTES),
		.MAX_SLOTS          (MAX_SLOTS),
		.MAX_REFLECTED_ROWS (MAX_REFLECTED_ROWS)
	) u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (byte_in.valid),
		.in_ready        (byte_in.ready),
		.data_byte       (byte_in.data_byte),
		.fragment_number (byte_in.fragment_number),
		.fragment_start  (byte_in.fragment_start),
		.cfg             (cfg),
		.adv             (adv),
		.res_valid       (res_valid),
		.res             (res)
	);

	// Result register; advance whenever it is empty or being drained
	lfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.adv       (adv),
		.out_valid (pixel_out.valid),
		.out_ready (pixel_out.ready),
		.out_pix   (out_pix)
	);

	assign pixel_out.pixel_kind        = out_pix.pixel_kind;
	assign pixel_out.row               = out_pix.row;
	assign pixel_out.column            = out_pix.column;
	assign pixel_out.pixel_value       = out_pix.pixel_value;
	assign pixel_out.intensity         = out_pix.intensity;
	assign pixel_out.distance_invalid  = out_pix.distance_invalid;
	assign pixel_out.intensity_clamped = out_pix.intensity_clamped;
	assign pixel_out.fragment_done     = out_pix.fragment_done;

	// Fragment end is only ever marked on a reflected write
	a_done_reflected: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid && pixel_out.fragment_done |->
			pixel_out.pixel_kind == KIND_REFLECTED)
		else $error("fragment_done on an ambient pixel");

	// An out-of-range distance is replaced by zero
	a_dist_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid && pixel_out.distance_invalid |-> pixel_out.pixel_value == '0)
		else $error("invalid distance not zeroed");

	// A clamped intensity equals the configured maximum
	a_inten_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid && pixel_out.intensity_clamped |->
			pixel_out.intensity == cfg.max_intensity)
		else $error("clamped intensity differs from maximum");

	// A byte just taken must not be overwritten while the result side is blocked
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		byte_in.valid && byte_in.ready |=> adv || !byte_in.ready)
		else $error("input register accepted over a held byte");

endmodule
`default_nettype wire
